// ===== design/hta_pkg.sv =====
// Package for the humidity/temperature averager: item types, register codes,
// conversion constants and the divide-by-sample-count helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hta_pkg;

    // Number of items averaged into one result (1..8)
    localparam int SAMPLES_PER_AVERAGE = 5;
    localparam int COUNT_W             = 3;

    // Conversion scales: hundredths of a degree / of percent over full scale
    localparam int                 TEMP_SCALE  = 17500;
    localparam int                 HUMI_SCALE  = 10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam int                 PROD_T_W    = 31;
    localparam int                 PROD_H_W    = 30;

    // Register reset values
    localparam logic signed [14:0] TEMP_MIN_RESET = -15'sd2000;
    localparam logic signed [14:0] TEMP_MAX_RESET = 15'sd12500;
    localparam logic [13:0]        HUMI_MIN_RESET = 14'd0;
    localparam logic [13:0]        HUMI_MAX_RESET = 14'd10000;

    // Running sums and the magnitude fed to the constant divider
    localparam int TSUM_W = 18;
    localparam int HSUM_W = 17;
    localparam int MAG_W  = 17;

    // Exact division by the sample count through a rounded-up reciprocal
    localparam int                    DIV_SHIFT  = MAG_W + COUNT_W;
    localparam int                    DIV_RECIP_W = DIV_SHIFT + 1;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP  =
        DIV_RECIP_W'(((64'd1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
    localparam int                    DIV_PROD_W = MAG_W + DIV_RECIP_W;

    localparam int CFG_DATA_W = 15;

    typedef enum logic [1:0] {
        REG_TEMP_MIN = 2'd0,
        REG_TEMP_MAX = 2'd1,
        REG_HUMI_MIN = 2'd2,
        REG_HUMI_MAX = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        logic        read_ok;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] avg_temperature;
        logic [13:0]        avg_humidity;
    } out_item_t;

    // Classified reading passed from front to back
    typedef struct packed {
        logic               accept;
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
    } cls_item_t;

    function automatic logic [MAG_W-1:0] div_samples(input logic [MAG_W-1:0] x);
        logic [DIV_PROD_W-1:0] p;
        p = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_RECIP);
        return p[DIV_SHIFT +: MAG_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/hta_front.sv =====
// Front end: limit registers, raw-to-centi conversion and range check.
// Depends on hta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hta_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire hta_pkg::in_item_t                sample,
    input  wire logic                             cfg_wr_en,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [hta_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  cls_valid,
    input  wire logic                             cls_ready,
    output hta_pkg::cls_item_t                    cls_item
);

    logic signed [14:0] temp_min_reg;
    logic signed [14:0] temp_max_reg;
    logic [13:0]        humi_min_reg;
    logic [13:0]        humi_max_reg;

    logic                          valid_reg, valid_next;
    logic [hta_pkg::PROD_T_W-1:0]  prod_t_reg, prod_t_next;
    logic [hta_pkg::PROD_H_W-1:0]  prod_h_reg, prod_h_next;
    logic                          ok_reg;

    logic                          advance;
    logic                          accept;
    logic [31:0]                   sum_t;
    logic [30:0]                   sum_h;
    logic [15:0]                   quo_t;
    logic signed [15:0]            conv_t_wide;
    logic signed [14:0]            conv_t;
    logic [13:0]                   conv_h;
    logic                          in_range;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_min_reg <= hta_pkg::TEMP_MIN_RESET;
            temp_max_reg <= hta_pkg::TEMP_MAX_RESET;
            humi_min_reg <= hta_pkg::HUMI_MIN_RESET;
            humi_max_reg <= hta_pkg::HUMI_MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (hta_pkg::cfg_reg_t'(cfg_index))
                hta_pkg::REG_TEMP_MIN: temp_min_reg <= cfg_data;
                hta_pkg::REG_TEMP_MAX: temp_max_reg <= cfg_data;
                hta_pkg::REG_HUMI_MIN: humi_min_reg <= cfg_data[13:0];
                hta_pkg::REG_HUMI_MAX: humi_max_reg <= cfg_data[13:0];
            endcase
        end
    end

    // Stage holds the scaled products; it advances when it is empty or the queue has room
    assign advance    = !valid_reg || cls_ready;
    assign full       = !advance;
    assign accept     = push && advance;
    assign valid_next = advance ? push : valid_reg;

    assign prod_t_next = hta_pkg::PROD_T_W'(sample.raw_temperature)
                       * hta_pkg::PROD_T_W'(hta_pkg::TEMP_SCALE);
    assign prod_h_next = hta_pkg::PROD_H_W'(sample.raw_humidity)
                       * hta_pkg::PROD_H_W'(hta_pkg::HUMI_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_t_reg <= prod_t_next;
            prod_h_reg <= prod_h_next;
            ok_reg     <= sample.read_ok;
        end
    end

    // Divide by 65535: (x + (x >> 16) + 1) >> 16 is exact for quotients below 65536
    always_comb
    begin
        sum_t       = 32'(prod_t_reg) + 32'(prod_t_reg >> 16) + 32'd1;
        sum_h       = 31'(prod_h_reg) + 31'(prod_h_reg >> 16) + 31'd1;
        quo_t       = sum_t[31:16];
        conv_t_wide = signed'({1'b0, quo_t[14:0]}) - hta_pkg::TEMP_OFFSET;
        conv_t      = conv_t_wide[14:0];
        conv_h      = sum_h[29:16];
        in_range    = (conv_t >= temp_min_reg) && (conv_t <= temp_max_reg)
                   && (conv_h >= humi_min_reg) && (conv_h <= humi_max_reg);
    end

    assign cls_valid            = valid_reg;
    assign cls_item.accept      = ok_reg && in_range;
    assign cls_item.temperature = conv_t;
    assign cls_item.humidity    = conv_h;

endmodule

`default_nettype wire

// ===== design/hta_queue.sv =====
// Two-entry queue of classified readings between front and back.
// Depends on hta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hta_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hta_pkg::cls_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hta_pkg::cls_item_t       out_item
);

    hta_pkg::cls_item_t mem [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// ===== design/hta_back.sv =====
// Back end: held values, running sums, averaging and the result queue.
// Depends on hta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hta_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hta_pkg::cls_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output hta_pkg::out_item_t       result
);

    logic signed [14:0]                  held_t_reg, held_t_next;
    logic [13:0]                         held_h_reg, held_h_next;
    logic signed [hta_pkg::TSUM_W-1:0]   sum_t_reg, sum_t_next;
    logic [hta_pkg::HSUM_W-1:0]          sum_h_reg, sum_h_next;
    logic [hta_pkg::COUNT_W-1:0]         count_reg, count_next;

    logic                                fire;
    logic                                last;
    logic signed [14:0]                  held_t_eff;
    logic [13:0]                         held_h_eff;
    logic signed [hta_pkg::TSUM_W-1:0]   sum_t_new;
    logic signed [hta_pkg::TSUM_W-1:0]   sum_t_neg;
    logic [hta_pkg::HSUM_W-1:0]          sum_h_new;
    logic [hta_pkg::MAG_W-1:0]           mag_t;
    logic [hta_pkg::MAG_W-1:0]           quo_t;
    logic [hta_pkg::MAG_W-1:0]           quo_h;
    logic signed [hta_pkg::TSUM_W-1:0]   avg_t_wide;
    hta_pkg::out_item_t                  avg;

    hta_pkg::out_item_t                  out_mem [2];
    logic                                owr_ptr_reg, orrd_ptr_reg;
    logic [1:0]                          ocount_reg;
    logic                                do_pop;

    assign in_ready = (ocount_reg != 2'd2);
    assign fire     = in_valid && in_ready;
    assign last     = (count_reg == hta_pkg::COUNT_W'(hta_pkg::SAMPLES_PER_AVERAGE - 1));

    always_comb
    begin
        held_t_eff = in_item.accept ? in_item.temperature : held_t_reg;
        held_h_eff = in_item.accept ? in_item.humidity    : held_h_reg;
        sum_t_new  = sum_t_reg + hta_pkg::TSUM_W'(held_t_eff);
        sum_h_new  = sum_h_reg + hta_pkg::HSUM_W'(held_h_eff);

        // Truncate toward zero: divide the magnitude, then restore the sign
        sum_t_neg  = -sum_t_new;
        mag_t      = sum_t_new[hta_pkg::TSUM_W-1] ? sum_t_neg[hta_pkg::MAG_W-1:0]
                                                  : sum_t_new[hta_pkg::MAG_W-1:0];
        quo_t      = hta_pkg::div_samples(mag_t);
        quo_h      = hta_pkg::div_samples(sum_h_new);
        avg_t_wide = sum_t_new[hta_pkg::TSUM_W-1] ? -signed'({1'b0, quo_t})
                                                  : signed'({1'b0, quo_t});
        avg.avg_temperature = avg_t_wide[14:0];
        avg.avg_humidity    = quo_h[13:0];
    end

    always_comb
    begin
        held_t_next = held_t_reg;
        held_h_next = held_h_reg;
        sum_t_next  = sum_t_reg;
        sum_h_next  = sum_h_reg;
        count_next  = count_reg;
        if (fire)
        begin
            if (last)
            begin
                held_t_next = avg.avg_temperature;
                held_h_next = avg.avg_humidity;
                sum_t_next  = '0;
                sum_h_next  = '0;
                count_next  = '0;
            end
            else
            begin
                held_t_next = held_t_eff;
                held_h_next = held_h_eff;
                sum_t_next  = sum_t_new;
                sum_h_next  = sum_h_new;
                count_next  = count_reg + hta_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_t_reg <= '0;
            held_h_reg <= '0;
            sum_t_reg  <= '0;
            sum_h_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            held_t_reg <= held_t_next;
            held_h_reg <= held_h_next;
            sum_t_reg  <= sum_t_next;
            sum_h_reg  <= sum_h_next;
            count_reg  <= count_next;
        end
    end

    // Result queue: two entries so a single waiting result does not block the next item
    assign empty  = (ocount_reg == 2'd0);
    assign do_pop = pop && !empty;
    assign result = out_mem[orrd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg  <= 1'b0;
            orrd_ptr_reg <= 1'b0;
            ocount_reg   <= 2'd0;
        end
        else
        begin
            if (fire && last)
                owr_ptr_reg <= !owr_ptr_reg;
            if (do_pop)
                orrd_ptr_reg <= !orrd_ptr_reg;
            ocount_reg <= ocount_reg + 2'(fire && last) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
            out_mem[owr_ptr_reg] <= avg;
    end

endmodule

`default_nettype wire

// ===== design/humidity_temperature_averager.sv =====
// Humidity and temperature averager, top level. Takes one raw sensor reading
// per cycle while full is low, converts it to hundredths of a degree and of
// percent, keeps the last in-limit reading (replaced by each group's average)
// and emits the average of every SAMPLES_PER_AVERAGE held values. An item is
// registered in the multiply stage of the front end, waits in the two-entry
// classified-item queue, and is folded into the sums by the back end, which
// writes each average into the two-entry result queue read by the result
// ports. full rises only once the multiply stage, the item queue and the
// two-entry result queue are all backed up because pop is held low.
// Depends on hta_pkg, hta_front, hta_queue and hta_back.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temperature_averager (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire hta_pkg::in_item_t                sample,
    output logic                                  empty,
    input  wire logic                             pop,
    output hta_pkg::out_item_t                    result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [hta_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               front_valid;
    logic               front_ready;
    hta_pkg::cls_item_t front_item;
    logic               back_valid;
    logic               back_ready;
    hta_pkg::cls_item_t back_item;

    hta_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cls_valid (front_valid),
        .cls_ready (front_ready),
        .cls_item  (front_item)
    );

    hta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    hta_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (back_valid),
        .in_ready (back_ready),
        .in_item  (back_item),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== design/hta_checker.sv =====
// Port-level checks for the humidity/temperature averager, bound to the top.
// Depends on hta_pkg and humidity_temperature_averager.
`timescale 1ns / 1ps
`default_nettype none

module hta_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pop,
    input wire logic               empty,
    input wire hta_pkg::out_item_t result
);

    // Averages of converted values never leave the conversion range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.avg_temperature >= -15'sd4500)
                && (result.avg_temperature <= 15'sd13000))
        else $error("average temperature out of range");

    a_humi_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.avg_humidity <= 14'd10000))
        else $error("average humidity out of range");

    // A waiting result stays until taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("waiting result changed");

endmodule

bind humidity_temperature_averager hta_checker u_hta_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire

// ===== bench/tb_humidity_temperature_averager.sv =====
// Testbench for humidity_temperature_averager: directed table plus random
// readings, every average checked against an in-bench model or a typed row.
// Depends on hta_pkg and the humidity_temperature_averager RTL.
`timescale 1ns / 1ps

module tb_humidity_temperature_averager;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 110;

    typedef enum {ROW_ITEM, ROW_LIMITS} row_kind_t;
    typedef enum {LIM_WIDE, LIM_WINDOW, LIM_RAW, LIM_RESET} limit_mode_t;

    // Item row: a/b raw words, c/d expected averages when typed.
    // Limits row: a..d are temp min, temp max, humi min, humi max.
    typedef struct {
        row_kind_t kind;
        int        a;
        int        b;
        int        c;
        int        d;
        bit        ok;
        bit        typed;
    } stim_row_t;

    logic                gen_clk_dummy_unused_guard;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    hta_pkg::in_item_t   reading = '0;
    logic                empty;
    logic                pop = 1'b0;
    hta_pkg::out_item_t  avg_out;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = hta_pkg::REG_TEMP_MIN;
    logic [hta_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Model state
    int lim_temp_min = -2000;
    int lim_temp_max = 12500;
    int lim_humi_min = 0;
    int lim_humi_max = 10000;
    int held_temp = 0;
    int held_humi = 0;
    int temp_sum = 0;
    int humi_sum = 0;
    int fill_count = 0;

    hta_pkg::out_item_t pending_averages[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    bit                 pop_steady = 1'b0;
    int                 stall_left = 0;
    stim_row_t          directed[$];

    humidity_temperature_averager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (reading),
        .empty     (empty),
        .pop       (pop),
        .result    (avg_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Fold one accepted reading into the held values and the sums
    function automatic void fold_reading(input hta_pkg::in_item_t it, output bit done,
                                         output hta_pkg::out_item_t avg);
        int t;
        int h;
        int avg_t;
        int avg_h;
        done = 1'b0;
        avg = '0;
        if (it.read_ok)
        begin
            t = int'((longint'(it.raw_temperature) * hta_pkg::TEMP_SCALE) / 65535) - 4500;
            h = int'((longint'(it.raw_humidity) * hta_pkg::HUMI_SCALE) / 65535);
            if (t >= lim_temp_min && t <= lim_temp_max &&
                h >= lim_humi_min && h <= lim_humi_max)
            begin
                held_temp = t;
                held_humi = h;
            end
        end
        temp_sum += held_temp;
        humi_sum += held_humi;
        fill_count++;
        if (fill_count >= hta_pkg::SAMPLES_PER_AVERAGE)
        begin
            avg_t = temp_sum / hta_pkg::SAMPLES_PER_AVERAGE;
            avg_h = humi_sum / hta_pkg::SAMPLES_PER_AVERAGE;
            held_temp = avg_t;
            held_humi = avg_h;
            temp_sum = 0;
            humi_sum = 0;
            fill_count = 0;
            avg.avg_temperature = avg_t[14:0];
            avg.avg_humidity = avg_h[13:0];
            done = 1'b1;
        end
    endfunction

    task automatic send_reading(input hta_pkg::in_item_t it, input bit typed,
                                input hta_pkg::out_item_t typed_avg);
        bit                 done;
        hta_pkg::out_item_t avg;
        reading <= it;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        fold_reading(it, done, avg);
        if (done)
            pending_averages.push_back(typed ? typed_avg : avg);
    endtask

    // Drop push, wait for every pending average, then let the pipe empty
    task automatic settle();
        push <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_limits(input logic [14:0] tmin, input logic [14:0] tmax,
                                input logic [14:0] hmin, input logic [14:0] hmax);
        hta_pkg::cfg_reg_t regs[4];
        logic [14:0]       vals[4];
        regs = '{hta_pkg::REG_TEMP_MIN, hta_pkg::REG_TEMP_MAX,
                 hta_pkg::REG_HUMI_MIN, hta_pkg::REG_HUMI_MAX};
        vals = '{tmin, tmax, hmin, hmax};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        lim_temp_min = int'($signed(tmin));
        lim_temp_max = int'($signed(tmax));
        lim_humi_min = int'(hmin[13:0]);
        lim_humi_max = int'(hmax[13:0]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: pop with random stalls, mostly short, none in the steady-pop phase
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left != 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else
        begin
            pop <= 1'b1;
            if (!pop_steady)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 24)
                    stall_left = $urandom_range(12, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        hta_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_averages.size() == 0)
                report_mismatch("unexpected result, avg_temperature",
                                int'(avg_out.avg_temperature), 0);
            else
            begin
                want = pending_averages.pop_front();
                if (avg_out.avg_temperature !== want.avg_temperature)
                    report_mismatch("avg_temperature", int'(avg_out.avg_temperature),
                                    int'(want.avg_temperature));
                if (avg_out.avg_humidity !== want.avg_humidity)
                    report_mismatch("avg_humidity", int'(avg_out.avg_humidity),
                                    int'(want.avg_humidity));
            end
        end
    end

    initial
    begin
        hta_pkg::in_item_t  it;
        hta_pkg::out_item_t typed_avg;
        limit_mode_t        modes[5];
        int                 r;
        int                 gap;
        int                 tlo;
        int                 thi;
        int                 hlo;
        int                 hhi;
        bit                 send_steady;

        directed = '{
            // failed reads straight after reset: held values stay zero
            '{ROW_ITEM, 'hFFFF, 'h0000, 0, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'h0000, 'hFFFF, 0, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 0, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'h5555, 'hAAAA, 0, 0, 1'b0, 1'b1},
            // mid-scale reading, readings outside the reset limits, a failed read, an in-range one
            '{ROW_ITEM, 'h8000, 'h8000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h8000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'h8000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h8000, 'hFFFF, 0, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'h4000, 'h2000, 0, 0, 1'b1, 1'b0},
            // widest limits: both ends of the scale get through
            '{ROW_LIMITS, -4500, 13000, 0, 10000, 1'b0, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, -4500, 0, 1'b1, 1'b1},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'hFFFF, 13000, 10000, 1'b1, 1'b1},
            // inverted limits reject everything, the held values carry over
            '{ROW_LIMITS, 13000, -4500, 10000, 0, 1'b0, 1'b0},
            '{ROW_ITEM, 'h8000, 'h8000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h0000, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hFFFF, 'h0000, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'h1234, 'hFEDC, 0, 0, 1'b1, 1'b0},
            '{ROW_ITEM, 'hC000, 'h4000, 13000, 10000, 1'b1, 1'b1}
        };
        modes = '{LIM_WINDOW, LIM_WIDE, LIM_RAW, LIM_WINDOW, LIM_RESET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_LIMITS)
            begin
                settle();
                apply_limits(15'(directed[i].a), 15'(directed[i].b),
                             15'(directed[i].c), 15'(directed[i].d));
            end
            else
            begin
                it.raw_temperature = 16'(directed[i].a);
                it.raw_humidity = 16'(directed[i].b);
                it.read_ok = directed[i].ok;
                typed_avg.avg_temperature = 15'(directed[i].c);
                typed_avg.avg_humidity = 14'(directed[i].d);
                send_reading(it, directed[i].typed, typed_avg);
                gap = pick_gap();
                if (gap != 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        for (int phase = 0; phase < 5; phase++)
        begin
            settle();
            case (modes[phase])
                LIM_WIDE:
                    apply_limits(-15'sd4500, 15'sd13000, 15'd0, 15'd10000);
                LIM_RESET:
                    apply_limits(hta_pkg::TEMP_MIN_RESET, hta_pkg::TEMP_MAX_RESET,
                                 15'(hta_pkg::HUMI_MIN_RESET),
                                 15'(hta_pkg::HUMI_MAX_RESET));
                LIM_RAW:
                    apply_limits(15'($urandom), 15'($urandom), 15'($urandom),
                                 15'($urandom));
                default:
                begin
                    tlo = $urandom_range(0, 17500) - 4500;
                    thi = $urandom_range(0, 17500) - 4500;
                    hlo = $urandom_range(0, 10000);
                    hhi = $urandom_range(0, 10000);
                    if (tlo > thi)
                    begin
                        r = tlo;
                        tlo = thi;
                        thi = r;
                    end
                    if (hlo > hhi)
                    begin
                        r = hlo;
                        hlo = hhi;
                        hhi = r;
                    end
                    apply_limits(15'(tlo), 15'(thi), 15'(hlo), 15'(hhi));
                end
            endcase
            send_steady = (phase == 1);
            pop_steady = (phase == 3);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the sender until the result side has caught up
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    settle();
                r = $urandom_range(0, 99);
                it.read_ok = (r >= 10);
                if (r >= 10 && r < 18)
                begin
                    it.raw_temperature = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    it.raw_humidity = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                else
                begin
                    it.raw_temperature = 16'($urandom);
                    it.raw_humidity = 16'($urandom);
                end
                send_reading(it, 1'b0, '0);
                gap = send_steady ? 0 : pick_gap();
                if (gap != 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
